/* rtl/core/dpx_pkg.sv */
// Shared types and constants for the data-processing execute core.
// No dependencies; dpx_regfile, dpx_exec and the core top level import this package.
package dpx_pkg;

    // Register file geometry
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);

    // Flag bit positions in the NZCV nibble
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // Instruction classes
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_MUL   = 2'd1,
        KIND_XFER  = 2'd2,
        KIND_BRANCH = 2'd3
    } t_kind;

    // Multiply signature in bits 7:4
    localparam logic [3:0] MUL_SIG = 4'b1001;

    // Data-processing opcodes that the core handles
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13
    } t_opcode;

    // Condition codes that can pass
    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14
    } t_cond;

    // Shift types for a register operand
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    // Outcome of one instruction, from the execute logic to the top level
    typedef struct packed {
        t_kind             kind;
        logic              halt;
        logic              executed;
        logic              bad_opcode;
        logic              wrote_register;
        logic [REG_AW-1:0] dest_index;
        logic [31:0]       alu_result;
        logic [3:0]        flags_after;
    } t_exec_res;

endpackage

/* rtl/core/dpx_if.sv */
// Valid/ready channel interfaces for the execute core.
// No dependencies; used by the top level and the test environment.
interface dpx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface dpx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        halt;
    logic        executed;
    logic        bad_opcode;
    logic        wrote_register;
    logic [3:0]  dest_index;
    logic [31:0] alu_result;
    logic [3:0]  flags_after;

    modport source (
        output valid, output kind, output halt, output executed, output bad_opcode,
        output wrote_register, output dest_index, output alu_result, output flags_after,
        input ready
    );
    modport sink (
        input valid, input kind, input halt, input executed, input bad_opcode,
        input wrote_register, input dest_index, input alu_result, input flags_after,
        output ready
    );
endinterface

/* rtl/core/dpx_regfile.sv */
// Register file: 16 x 32 storage, one write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on dpx_pkg.
module dpx_regfile
    import dpx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [REG_AW-1:0] i_rd_addr_a,
    input  logic [REG_AW-1:0] i_rd_addr_b,
    input  logic              i_wr_en,
    input  logic [REG_AW-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    output logic [31:0]       o_rd_a,
    output logic [31:0]       o_rd_b
);

    logic [31:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [31:0]          r_rd_a;
    logic [31:0]          r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Clear valid bits on reset, mark on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Read ports: bypass a write landing on the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
                r_rd_a <= i_wr_data;
            end else begin
                r_rd_a <= r_vld[i_rd_addr_a] ? r_mem[i_rd_addr_a] : 32'd0;
            end
            if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
                r_rd_b <= i_wr_data;
            end else begin
                r_rd_b <= r_vld[i_rd_addr_b] ? r_mem[i_rd_addr_b] : 32'd0;
            end
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

/* rtl/core/dpx_exec.sv */
// Execute logic: decode, condition check, barrel shifter and ALU for one word.
// Purely combinational; returns the outcome and the register write request.
// Depends on dpx_pkg.
module dpx_exec
    import dpx_pkg::*;
(
    input  logic [31:0]       i_word,
    input  logic [31:0]       i_rn_data,
    input  logic [31:0]       i_rm_data,
    input  logic [3:0]        i_flags,
    output t_exec_res         o_res,
    output logic              o_wr_en
);

    logic        is_zero;
    logic        is_data;
    t_kind       kind;
    logic        cond_ok;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic [4:0]  sh_amt;
    logic [32:0] lsl_ext;
    logic [32:0] rsh_ext;
    logic [63:0] ror_ext;
    logic [31:0] sh_val;
    logic        sh_carry;
    logic [3:0]  imm_rot;
    logic [63:0] imm_ext;
    logic [31:0] op_b;
    logic [32:0] sum;
    logic [32:0] diff_ab;
    logic [32:0] diff_ba;
    logic [31:0] result;
    logic        carry;
    logic        supported;
    logic        writes;
    logic        executed;
    logic [3:0]  n_flags;

    // Classify the word
    always_comb begin
        is_zero = (i_word == 32'd0);
        if (is_zero) begin
            kind = KIND_DATA;
        end else if (i_word[27:26] == 2'd1) begin
            kind = KIND_XFER;
        end else if (i_word[27:26] == 2'd2) begin
            kind = KIND_BRANCH;
        end else if ((i_word[27:22] == 6'd0) && (i_word[7:4] == MUL_SIG)) begin
            kind = KIND_MUL;
        end else begin
            kind = KIND_DATA;
        end
        is_data = !is_zero && (kind == KIND_DATA);
    end

    // Check the condition against the current flags
    always_comb begin
        flag_n = i_flags[FLAG_N];
        flag_z = i_flags[FLAG_Z];
        flag_v = i_flags[FLAG_V];
        case (t_cond'(i_word[31:28]))
            COND_EQ: cond_ok = flag_z;
            COND_NE: cond_ok = !flag_z;
            COND_GE: cond_ok = (flag_n == flag_v);
            COND_LT: cond_ok = (flag_n != flag_v);
            COND_GT: cond_ok = !flag_z && (flag_n == flag_v);
            COND_LE: cond_ok = flag_z || (flag_n != flag_v);
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    // Shift the register operand by the constant amount
    always_comb begin
        sh_amt  = i_word[11:7];
        lsl_ext = {1'b0, i_rm_data} << sh_amt;
        rsh_ext = {i_rm_data, 1'b0} >> sh_amt;
        ror_ext = {i_rm_data, i_rm_data} >> sh_amt;
        if (sh_amt == 5'd0) begin
            sh_val   = i_rm_data;
            sh_carry = 1'b0;
        end else begin
            case (t_shift'(i_word[6:5]))
                SH_LSL: begin
                    sh_val   = lsl_ext[31:0];
                    sh_carry = lsl_ext[32];
                end
                SH_LSR: begin
                    sh_val   = rsh_ext[32:1];
                    sh_carry = rsh_ext[0];
                end
                SH_ASR: begin
                    sh_val   = $unsigned($signed(i_rm_data) >>> sh_amt);
                    sh_carry = rsh_ext[0];
                end
                default: begin
                    sh_val   = ror_ext[31:0];
                    sh_carry = rsh_ext[0];
                end
            endcase
        end
    end

    // Rotate the 8-bit immediate by twice the rotate field
    always_comb begin
        imm_rot = i_word[11:8];
        imm_ext = {24'd0, i_word[7:0], 24'd0, i_word[7:0]} >> {imm_rot, 1'b0};
    end

    // Pick the second operand
    always_comb begin
        if (i_word[25]) begin
            op_b = imm_ext[31:0];
        end else begin
            op_b = sh_val;
        end
    end

    // Run the operation
    always_comb begin
        sum     = {1'b0, i_rn_data} + {1'b0, op_b};
        diff_ab = {1'b0, i_rn_data} - {1'b0, op_b};
        diff_ba = {1'b0, op_b} - {1'b0, i_rn_data};
        carry     = i_word[25] ? i_flags[FLAG_C] : sh_carry;
        supported = 1'b1;
        writes    = 1'b1;
        case (t_opcode'(i_word[24:21]))
            OP_AND: result = i_rn_data & op_b;
            OP_TST: begin
                result = i_rn_data & op_b;
                writes = 1'b0;
            end
            OP_EOR: result = i_rn_data ^ op_b;
            OP_TEQ: begin
                result = i_rn_data ^ op_b;
                writes = 1'b0;
            end
            OP_ORR: result = i_rn_data | op_b;
            OP_MOV: result = op_b;
            OP_ADD: begin
                result = sum[31:0];
                carry  = sum[32];
            end
            OP_SUB: begin
                result = diff_ab[31:0];
                carry  = !diff_ab[32];
            end
            OP_CMP: begin
                result = diff_ab[31:0];
                carry  = !diff_ab[32];
                writes = 1'b0;
            end
            OP_RSB: begin
                result = diff_ba[31:0];
                carry  = !diff_ba[32];
            end
            default: begin
                result    = 32'd0;
                supported = 1'b0;
                writes    = 1'b0;
            end
        endcase
    end

    // Assemble the outcome and the new flags
    always_comb begin
        executed = is_data && cond_ok;
        n_flags  = i_flags;
        if (executed && supported && i_word[20]) begin
            n_flags[FLAG_N] = result[31];
            n_flags[FLAG_Z] = (result == 32'd0);
            n_flags[FLAG_C] = carry;
        end
        o_res.kind           = kind;
        o_res.halt           = is_zero;
        o_res.executed       = executed;
        o_res.bad_opcode     = executed && !supported;
        o_res.wrote_register = executed && writes;
        o_res.dest_index     = is_data ? i_word[15:12] : '0;
        o_res.alu_result     = executed ? result : 32'd0;
        o_res.flags_after    = n_flags;
        o_wr_en              = executed && writes;
    end

endmodule

/* rtl/core/arm_data_processing_execute_core.sv */
// Data-processing execute core: instruction register, execute logic, result register.
// An accepted instruction passes the instruction register, then the result register.
// Throughput: 1 instruction per cycle while results are taken; operand reads, shift, ALU
// and write-back of one instruction fit between the instruction and result registers.
// Reset (synchronous, active low) clears the register file, the flags and both valids.
// Depends on dpx_pkg, dpx_if, dpx_regfile and dpx_exec.
module arm_data_processing_execute_core
    import dpx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dpx_in_if.sink           i_in,
    dpx_out_if.source        o_out
);

    logic        r_in_valid;
    logic [31:0] r_word;
    logic        r_out_valid;
    t_exec_res   r_out;
    logic [3:0]  r_flags;

    logic        advance;
    logic        in_fire;
    logic        exec_fire;
    logic [31:0] rn_data;
    logic [31:0] rm_data;
    t_exec_res   exec_res;
    logic        exec_wr;
    logic        rf_wr_en;

    // Handshake: the instruction register moves on when the result slot frees up
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;
    assign exec_fire  = r_in_valid && advance;
    assign rf_wr_en   = exec_fire && exec_wr;

    // Register file with operand reads issued as the transaction is accepted
    dpx_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (i_in.instruction_word[19:16]),
        .i_rd_addr_b (i_in.instruction_word[3:0]),
        .i_wr_en     (rf_wr_en),
        .i_wr_addr   (exec_res.dest_index),
        .i_wr_data   (exec_res.alu_result),
        .o_rd_a      (rn_data),
        .o_rd_b      (rm_data)
    );

    // Decode, shift and ALU
    dpx_exec u_exec (
        .i_word    (r_word),
        .i_rn_data (rn_data),
        .i_rm_data (rm_data),
        .i_flags   (r_flags),
        .o_res     (exec_res),
        .o_wr_en   (exec_wr)
    );

    // Instruction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= i_in.instruction_word;
        end
    end

    // Status flags: commit on execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 4'd0;
        end else if (exec_fire) begin
            r_flags <= exec_res.flags_after;
        end
    end

    // Result register: load on execute, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out <= exec_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.halt           = r_out.halt;
    assign o_out.executed       = r_out.executed;
    assign o_out.bad_opcode     = r_out.bad_opcode;
    assign o_out.wrote_register = r_out.wrote_register;
    assign o_out.dest_index     = r_out.dest_index;
    assign o_out.alu_result     = r_out.alu_result;
    assign o_out.flags_after    = r_out.flags_after;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for arm_data_processing_execute_core: directed table, then random words.
// A shadow register file and NZCV flags predict each result transaction not typed into the table.
// Depends on dpx_pkg, dpx_if and the execute core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpx_pkg::*;

    // Instruction field values without a name in the package
    localparam logic [1:0] DP_CLASS     = 2'b00;
    localparam logic [1:0] XFER_CLASS   = 2'b01;
    localparam logic [1:0] BRANCH_CLASS = 2'b10;
    localparam logic       IMM_OP       = 1'b1;
    localparam logic       REG_OP       = 1'b0;
    localparam logic       SET_NZC      = 1'b1;
    localparam logic       KEEP_NZC     = 1'b0;
    localparam logic [3:0] OP_ADC       = 4'd5;
    localparam logic [3:0] COND_NV      = 4'd15;
    localparam int         RANDOM_WORDS = 700;

    logic i_clk;
    logic i_rst_n;

    dpx_in_if  in_ch ();
    dpx_out_if out_ch ();

    arm_data_processing_execute_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // One directed transaction; known holds a typed-in result when typed is set
    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        t_exec_res   known;
    } t_stim_row;

    t_stim_row directed_rows [26] = '{
        // all-zero word halts
        '{32'h0000_0000, 1'b1, '{KIND_DATA, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 4'd0}},
        // all-ones word: data class, never-condition fails, dest still reported
        '{32'hFFFF_FFFF, 1'b1, '{KIND_DATA, 1'b0, 1'b0, 1'b0, 1'b0, 4'd15, 32'd0, 4'd0}},
        '{{COND_AL, 6'd0, 2'b00, 4'd1, 4'd2, 4'd3, MUL_SIG, 4'd4}, 1'b1,
          '{KIND_MUL, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 4'd0}},
        '{{COND_AL, XFER_CLASS, 26'h3FF_FFFF}, 1'b1,
          '{KIND_XFER, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 4'd0}},
        '{{COND_NV, BRANCH_CLASS, 26'h000_0000}, 1'b1,
          '{KIND_BRANCH, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'd0, 4'd0}},
        // unsupported opcode: error, no write, no flag change
        '{{COND_AL, DP_CLASS, IMM_OP, OP_ADC, SET_NZC, 4'd0, 4'd2, 4'd0, 8'hFF}, 1'b1,
          '{KIND_DATA, 1'b0, 1'b1, 1'b1, 1'b0, 4'd2, 32'd0, 4'd0}},
        '{{COND_AL, DP_CLASS, IMM_OP, OP_MOV, SET_NZC, 4'd0, 4'd1, 4'd0, 8'hFF}, 1'b1,
          '{KIND_DATA, 1'b0, 1'b1, 1'b0, 1'b1, 4'd1, 32'h0000_00FF, 4'd0}},
        '{{COND_NV, DP_CLASS, IMM_OP, OP_MOV, SET_NZC, 4'd0, 4'd5, 4'd0, 8'hFF}, 1'b1,
          '{KIND_DATA, 1'b0, 1'b0, 1'b0, 1'b0, 4'd5, 32'd0, 4'd0}},
        // rotated immediate, then every shift type, some at extreme amounts
        '{{COND_AL, DP_CLASS, IMM_OP, OP_MOV, SET_NZC, 4'd0, 4'd2, 4'd1, 8'hFF}, 1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_MOV, SET_NZC, 4'd0, 4'd4, 5'd31, SH_ASR, 1'b0, 4'd2},
          1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_MOV, SET_NZC, 4'd0, 4'd5, 5'd31, SH_LSL, 1'b0, 4'd1},
          1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_MOV, SET_NZC, 4'd0, 4'd6, 5'd1, SH_LSR, 1'b0, 4'd2},
          1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_MOV, SET_NZC, 4'd0, 4'd7, 5'd4, SH_ROR, 1'b0, 4'd2},
          1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_MOV, SET_NZC, 4'd0, 4'd8, 5'd0, SH_ROR, 1'b0, 4'd2},
          1'b0, '0},
        // bit 4 set: still a constant shift
        '{{COND_AL, DP_CLASS, REG_OP, OP_ORR, SET_NZC, 4'd1, 4'd9, 5'd3, SH_LSL, 1'b1, 4'd2},
          1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_ADD, SET_NZC, 4'd4, 4'd10, 5'd0, SH_LSL, 1'b0, 4'd1},
          1'b0, '0},
        '{{COND_AL, DP_CLASS, REG_OP, OP_SUB, SET_NZC, 4'd1, 4'd11, 5'd0, SH_LSL, 1'b0, 4'd1},
          1'b0, '0},
        '{{COND_EQ, DP_CLASS, IMM_OP, OP_AND, KEEP_NZC, 4'd4, 4'd12, 4'd0, 8'h0F}, 1'b0, '0},
        '{{COND_NE, DP_CLASS, IMM_OP, OP_MOV, SET_NZC, 4'd0, 4'd13, 4'd0, 8'h01}, 1'b0, '0},
        '{{COND_AL, DP_CLASS, IMM_OP, OP_RSB, SET_NZC, 4'd1, 4'd13, 4'd0, 8'h10}, 1'b0, '0},
        '{{COND_AL, DP_CLASS, IMM_OP, OP_CMP, SET_NZC, 4'd1, 4'd0, 4'd0, 8'hFF}, 1'b0, '0},
        '{{COND_AL, DP_CLASS, IMM_OP, OP_TST, SET_NZC, 4'd4, 4'd0, 4'd1, 8'h02}, 1'b0, '0},
        '{{COND_GE, DP_CLASS, REG_OP, OP_TEQ, SET_NZC, 4'd2, 4'd0, 5'd0, SH_LSL, 1'b0, 4'd2},
          1'b0, '0},
        '{{COND_LT, DP_CLASS, IMM_OP, OP_EOR, KEEP_NZC, 4'd2, 4'd14, 4'd0, 8'hAA}, 1'b0, '0},
        '{{COND_GT, DP_CLASS, IMM_OP, OP_ADD, SET_NZC, 4'd15, 4'd15, 4'd15, 8'hFF}, 1'b0, '0},
        '{{COND_LE, DP_CLASS, REG_OP, OP_MOV, KEEP_NZC, 4'd0, 4'd3, 5'd16, SH_ASR, 1'b0, 4'd15},
          1'b0, '0}
    };

    logic [31:0] shadow_regs [REG_COUNT];
    logic [3:0]  shadow_flags;
    t_exec_res   pending_results [$];
    int          failures   = 0;
    int          burst_left = 0;

    // Evaluate a condition code against the shadow flags
    function automatic logic cond_holds(input logic [3:0] cond);
        logic n, z, v;
        n = shadow_flags[FLAG_N];
        z = shadow_flags[FLAG_Z];
        v = shadow_flags[FLAG_V];
        case (cond)
            COND_EQ: return z;
            COND_NE: return !z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Execute one word on the shadow state and return its result transaction
    function automatic t_exec_res execute_word(input logic [31:0] word);
        t_exec_res   res;
        logic [31:0] op_a, op_b, reg_val, imm_val;
        logic [32:0] sum;
        logic        carry, supported, write_back;
        int          amt, rot;
        res = '0;
        res.kind = KIND_DATA;
        if (word == '0) begin
            res.halt = 1'b1;
        end else if (word[27:26] == XFER_CLASS) begin
            res.kind = KIND_XFER;
        end else if (word[27:26] == BRANCH_CLASS) begin
            res.kind = KIND_BRANCH;
        end else if (word[27:22] == '0 && word[7:4] == MUL_SIG) begin
            res.kind = KIND_MUL;
        end else begin
            res.dest_index = word[15:12];
            if (cond_holds(word[31:28])) begin
                res.executed = 1'b1;
                op_a  = shadow_regs[word[19:16]];
                carry = shadow_flags[FLAG_C];
                if (word[25] == IMM_OP) begin
                    // rotated 8-bit immediate; carry left to the opcode
                    rot     = 2 * int'(word[11:8]);
                    imm_val = {24'd0, word[7:0]};
                    op_b    = (rot == 0) ? imm_val : ((imm_val >> rot) | (imm_val << (32 - rot)));
                end else begin
                    // register shifted by a constant; zero amount passes through, carry 0
                    reg_val = shadow_regs[word[3:0]];
                    amt     = int'(word[11:7]);
                    if (amt == 0) begin
                        op_b  = reg_val;
                        carry = 1'b0;
                    end else begin
                        case (word[6:5])
                            SH_LSL: begin
                                op_b  = reg_val << amt;
                                carry = reg_val[32 - amt];
                            end
                            SH_LSR: begin
                                op_b  = reg_val >> amt;
                                carry = reg_val[amt - 1];
                            end
                            SH_ASR: begin
                                op_b  = $signed(reg_val) >>> amt;
                                carry = reg_val[amt - 1];
                            end
                            default: begin
                                op_b  = (reg_val >> amt) | (reg_val << (32 - amt));
                                carry = reg_val[amt - 1];
                            end
                        endcase
                    end
                end

                supported  = 1'b1;
                write_back = !(word[24:21] == OP_TST || word[24:21] == OP_TEQ ||
                               word[24:21] == OP_CMP);
                case (word[24:21])
                    OP_AND, OP_TST: res.alu_result = op_a & op_b;
                    OP_EOR, OP_TEQ: res.alu_result = op_a ^ op_b;
                    OP_ORR:         res.alu_result = op_a | op_b;
                    OP_MOV:         res.alu_result = op_b;
                    OP_ADD: begin
                        sum            = {1'b0, op_a} + {1'b0, op_b};
                        res.alu_result = sum[31:0];
                        carry          = sum[32];
                    end
                    OP_SUB, OP_CMP: begin
                        res.alu_result = op_a - op_b;
                        carry          = op_b <= op_a;
                    end
                    OP_RSB: begin
                        res.alu_result = op_b - op_a;
                        carry          = op_a <= op_b;
                    end
                    default: supported = 1'b0;
                endcase

                // update state only for a supported opcode
                if (!supported) begin
                    res.bad_opcode = 1'b1;
                    res.alu_result = '0;
                end else begin
                    if (write_back) begin
                        shadow_regs[word[15:12]] = res.alu_result;
                        res.wrote_register       = 1'b1;
                    end
                    if (word[20] == SET_NZC) begin
                        shadow_flags = {res.alu_result[31], res.alu_result == '0, carry,
                                        shadow_flags[FLAG_V]};
                    end
                end
            end
        end
        res.flags_after = shadow_flags;
        return res;
    endfunction

    // Mostly well-formed data-processing words, with other classes and raw noise mixed in
    function automatic logic [31:0] random_word();
        logic [31:0] word;
        int unsigned pick;
        word = $urandom;
        pick = $urandom_range(99);
        if (pick < 8)
            return word;
        if (pick == 8)
            return '0;
        if (pick < 12) begin
            word[27:22] = '0;
            word[7:4]   = MUL_SIG;
        end else if (pick < 15) begin
            word[27:26] = XFER_CLASS;
        end else if (pick < 18) begin
            word[27:26] = BRANCH_CLASS;
        end else begin
            word[27:26] = DP_CLASS;
            case ($urandom_range(15))
                0: word[31:28] = COND_EQ;
                1: word[31:28] = COND_NE;
                2: word[31:28] = COND_GE;
                3: word[31:28] = COND_LT;
                4: word[31:28] = COND_GT;
                5: word[31:28] = COND_LE;
                6: ;
                default: word[31:28] = COND_AL;
            endcase
            if ($urandom_range(9) != 0) begin
                case ($urandom_range(9))
                    0: word[24:21] = OP_AND;
                    1: word[24:21] = OP_EOR;
                    2: word[24:21] = OP_SUB;
                    3: word[24:21] = OP_RSB;
                    4: word[24:21] = OP_ADD;
                    5: word[24:21] = OP_TST;
                    6: word[24:21] = OP_TEQ;
                    7: word[24:21] = OP_CMP;
                    8: word[24:21] = OP_ORR;
                    default: word[24:21] = OP_MOV;
                endcase
            end
        end
        return word;
    endfunction

    // Send one instruction transaction, with a random gap between bursts
    task automatic send_word(input logic [31:0] word, input logic typed, input t_exec_res known);
        t_exec_res predicted;
        int        gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid            <= 1'b1;
        in_ch.instruction_word <= word;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = execute_word(word);
        pending_results.push_back(typed ? known : predicted);
    endtask

    // Hold the sender until every pending result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    // Compare one result transaction with the oldest pending one
    task automatic check_result();
        t_exec_res want;
        if (pending_results.size() == 0) begin
            $error("result transaction with nothing pending: alu_result %h", out_ch.alu_result);
            failures++;
        end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(out_ch.kind));
            check_field("halt", 32'(want.halt), 32'(out_ch.halt));
            check_field("executed", 32'(want.executed), 32'(out_ch.executed));
            check_field("bad_opcode", 32'(want.bad_opcode), 32'(out_ch.bad_opcode));
            check_field("wrote_register", 32'(want.wrote_register),
                        32'(out_ch.wrote_register));
            check_field("dest_index", 32'(want.dest_index), 32'(out_ch.dest_index));
            check_field("alu_result", want.alu_result, out_ch.alu_result);
            check_field("flags_after", 32'(want.flags_after), 32'(out_ch.flags_after));
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result sink: stall on a rotating pattern, reloaded with all ones or a random pattern
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned stall_age     = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            check_result();
        stall_age <= stall_age + 1;
        if (stall_age % 64 == 63)
            stall_pattern <= ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        else
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        out_ch.ready <= stall_pattern[0];
    end

    // Stimulus and end of run
    initial begin
        in_ch.valid            = 1'b0;
        in_ch.instruction_word = '0;
        i_rst_n                = 1'b0;
        foreach (shadow_regs[r])
            shadow_regs[r] = '0;
        shadow_flags = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[r])
            send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].known);
        drain_results();

        // Random words, with one full drain halfway
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_word(random_word(), 1'b0, '0);
            if (n == RANDOM_WORDS / 2)
                drain_results();
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
